FILE: sv/tlc_pkg.sv
// Shared types, constants and the seven-segment table for the traffic light controller.
// No dependencies; every other file imports this package.
package tlc_pkg;

  localparam int unsigned DurW = 7;
  localparam logic [DurW-1:0] MaxSeconds = 7'd99;
  localparam logic [DurW-1:0] RedReset = 7'd10;
  localparam logic [DurW-1:0] GreenReset = 7'd10;
  localparam logic [DurW-1:0] YellowReset = 7'd3;
  localparam logic [DurW-1:0] DisplayMod = 7'd100;

  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhRed    = 2'd1,
    PhGreen  = 2'd2,
    PhYellow = 2'd3
  } phase_e;

  // Input item, lowest bit last.
  typedef struct packed {
    logic yellow_press;
    logic green_press;
    logic red_press;
    logic mode_adjust;
    logic mode_normal;
    logic second_tick;
  } in_item_t;

  // Result item, lowest bit last.
  typedef struct packed {
    logic       adjusting;
    logic [7:0] seg_tens;
    logic [7:0] seg_units;
    logic       lamp_green;
    logic       lamp_yellow;
    logic       lamp_red;
  } out_item_t;

  // State after one update, handed from the core to the output stage.
  typedef struct packed {
    phase_e          phase;
    logic            adjusting;
    logic [DurW-1:0] value;
  } core_res_t;

  // Common-anode digit patterns, active low, dp off.
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0: p = 8'b11000000;
      4'd1: p = 8'b11111001;
      4'd2: p = 8'b10100100;
      4'd3: p = 8'b10110000;
      4'd4: p = 8'b10011001;
      4'd5: p = 8'b10010010;
      4'd6: p = 8'b10000010;
      4'd7: p = 8'b11111000;
      4'd8: p = 8'b10000000;
      4'd9: p = 8'b10010000;
      default: p = 8'b11111111;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/tlc_core.sv
// Phase sequencer and duration store: updates the controller state for one item.
// Depends on tlc_pkg.
module tlc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tlc_pkg::in_item_t item_i,
  output tlc_pkg::core_res_t res_o
);
  import tlc_pkg::*;

  phase_e          phase_q, phase_d;
  logic [DurW-1:0] remaining_q, remaining_d;
  logic [DurW-1:0] red_dur_q, red_dur_d;
  logic [DurW-1:0] green_dur_q, green_dur_d;
  logic [DurW-1:0] yellow_dur_q, yellow_dur_d;
  logic [DurW-1:0] shown_q, shown_d;
  logic            adj;

  function automatic logic [DurW-1:0] bump(input logic [DurW-1:0] d);
    return (d < MaxSeconds) ? d + 7'd1 : 7'd1;
  endfunction

  always_comb begin
    phase_d      = phase_q;
    remaining_d  = remaining_q;
    red_dur_d    = red_dur_q;
    green_dur_d  = green_dur_q;
    yellow_dur_d = yellow_dur_q;
    shown_d      = shown_q;
    adj          = 1'b0;

    if (item_i.mode_adjust) begin
      phase_d     = PhIdle;
      remaining_d = '0;
      if (!item_i.mode_normal) begin
        adj = 1'b1;
        // later presses override shown value: red, then green, then yellow
        if (item_i.red_press) begin
          red_dur_d = bump(red_dur_q);
          shown_d   = red_dur_d;
        end
        if (item_i.green_press) begin
          green_dur_d = bump(green_dur_q);
          shown_d     = green_dur_d;
        end
        if (item_i.yellow_press) begin
          yellow_dur_d = bump(yellow_dur_q);
          shown_d      = yellow_dur_d;
        end
      end
    end else if (phase_q == PhIdle) begin
      if (item_i.mode_normal) begin
        phase_d     = PhRed;
        remaining_d = red_dur_q;
      end
    end else if (item_i.second_tick) begin
      if (remaining_q > 7'd1) begin
        remaining_d = remaining_q - 7'd1;
      end else begin
        case (phase_q)
          PhRed: begin
            phase_d     = PhGreen;
            remaining_d = green_dur_q;
          end
          PhGreen: begin
            phase_d     = PhYellow;
            remaining_d = yellow_dur_q;
          end
          PhYellow: begin
            if (item_i.mode_normal) begin
              phase_d     = PhRed;
              remaining_d = red_dur_q;
            end else begin
              phase_d     = PhIdle;
              remaining_d = '0;
            end
          end
          default: begin
            phase_d     = PhIdle;
            remaining_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      remaining_q  <= '0;
      red_dur_q    <= RedReset;
      green_dur_q  <= GreenReset;
      yellow_dur_q <= YellowReset;
      shown_q      <= '0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      remaining_q  <= remaining_d;
      red_dur_q    <= red_dur_d;
      green_dur_q  <= green_dur_d;
      yellow_dur_q <= yellow_dur_d;
      shown_q      <= shown_d;
    end
  end

  assign res_o.phase     = phase_d;
  assign res_o.adjusting = adj;
  assign res_o.value     = adj ? shown_d : remaining_d;

endmodule

FILE: sv/tlc_display.sv
// Lamp decode and two-digit seven-segment split of the shown value.
// Depends on tlc_pkg.
module tlc_display (
  input  tlc_pkg::core_res_t res_i,
  output tlc_pkg::out_item_t item_o
);
  import tlc_pkg::*;

  logic [DurW-1:0] val_mod;
  logic [13:0]     prod;
  logic [3:0]      tens;
  logic [DurW-1:0] tens_x10;
  logic [3:0]      units;

  always_comb begin
    // value is below 128, one subtract gives modulo 100
    val_mod  = (res_i.value >= DisplayMod) ? res_i.value - DisplayMod : res_i.value;
    // floor(v/10) = (v*103)>>10, exact for v below 100
    prod     = 14'(val_mod) * 14'd103;
    tens     = prod[13:10];
    tens_x10 = 7'(tens) * 7'd10;
    units    = 4'(val_mod - tens_x10);

    item_o.lamp_red    = (res_i.phase == PhRed);
    item_o.lamp_yellow = (res_i.phase == PhYellow);
    item_o.lamp_green  = (res_i.phase == PhGreen);
    item_o.seg_units   = digit_pattern(units);
    item_o.seg_tens    = digit_pattern(tens);
    item_o.adjusting   = res_i.adjusting;
  end

endmodule

FILE: sv/traffic_light_countdown_controller.sv
// Traffic light controller with two-digit countdown, top level.
// Path: input register, one update, result register.
// Throughput: one transaction per cycle while the master side does not stall (m_axis_tready).
// Reset: rst_ni asynchronous, active low; phase idle, durations 10/10/3, pipeline empty.
// Depends on tlc_pkg, tlc_core, tlc_display.
module traffic_light_countdown_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // second_tick, mode_normal, mode_adjust, red_press, green_press, yellow_press, 2'b0
  input  logic [tlc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // lamp_red, lamp_yellow, lamp_green, seg_units[7:0], seg_tens[7:0], adjusting, 4'b0
  output logic [tlc_pkg::OutDataW-1:0] m_axis_tdata
);
  import tlc_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      res_valid_q;
  out_item_t res_q;
  logic      advance;
  core_res_t core_res;
  out_item_t disp_item;

  assign advance       = in_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    end
    if (advance) begin
      res_q <= disp_item;
    end
  end

  tlc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .res_o  (core_res)
  );

  tlc_display u_display (
    .res_i  (core_res),
    .item_o (disp_item)
  );

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(out_item_t)){1'b0}}, res_q};

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for traffic_light_countdown_controller.
// Drives tick/switch/button items on the slave stream and checks each result against an
// in-bench model of the light sequencer; depends on tlc_pkg and the block's RTL.
module testbench;
  import tlc_pkg::*;

  localparam int unsigned HoldCycles = 150;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportMax = 10;
  localparam int unsigned RandomItems = 700;
  // digit 9 in the top byte down to digit 0 in the bottom byte, active low
  localparam logic [79:0] SegRom = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                    8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  traffic_light_countdown_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Model state of the light sequencer
  phase_e          ph = PhIdle;
  logic [DurW-1:0] remaining = '0;
  logic [DurW-1:0] dur_red = RedReset;
  logic [DurW-1:0] dur_green = GreenReset;
  logic [DurW-1:0] dur_yellow = YellowReset;
  logic [DurW-1:0] shown_dur = '0;

  out_item_t pending_lights[$];
  int unsigned fail_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet = 1'b0;
  bit          holding = 1'b0;
  int unsigned stall_left = 0;
  event        hold_ev;

  function automatic logic [DurW-1:0] bump_dur(input logic [DurW-1:0] d);
    return (d < MaxSeconds) ? d + 7'd1 : 7'd1;
  endfunction

  function automatic void advance_lights(input in_item_t it, output out_item_t res);
    logic adj;
    int   val;
    adj = 1'b0;
    if (it.mode_adjust) begin
      ph = PhIdle;
      remaining = '0;
      if (!it.mode_normal) begin
        adj = 1'b1;
        // red, green, yellow order: the last press wins the display
        if (it.red_press) begin
          dur_red = bump_dur(dur_red);
          shown_dur = dur_red;
        end
        if (it.green_press) begin
          dur_green = bump_dur(dur_green);
          shown_dur = dur_green;
        end
        if (it.yellow_press) begin
          dur_yellow = bump_dur(dur_yellow);
          shown_dur = dur_yellow;
        end
      end
    end else if (ph == PhIdle) begin
      // tick in the start cycle is dropped
      if (it.mode_normal) begin
        ph = PhRed;
        remaining = dur_red;
      end
    end else if (it.second_tick) begin
      if (remaining > 7'd1) begin
        remaining = remaining - 7'd1;
      end else if (ph == PhYellow) begin
        if (it.mode_normal) begin
          ph = PhRed;
          remaining = dur_red;
        end else begin
          ph = PhIdle;
          remaining = '0;
        end
      end else if (ph == PhRed) begin
        ph = PhGreen;
        remaining = dur_green;
      end else begin
        ph = PhYellow;
        remaining = dur_yellow;
      end
    end
    val = adj ? int'(shown_dur) : int'(remaining);
    val = val % 100;
    res.lamp_red = (ph == PhRed);
    res.lamp_yellow = (ph == PhYellow);
    res.lamp_green = (ph == PhGreen);
    res.seg_units = SegRom[(val % 10) * 8 +: 8];
    res.seg_tens = SegRom[(val / 10) * 8 +: 8];
    res.adjusting = adj;
  endfunction

  function automatic in_item_t pack_in(input bit tick, input bit norm, input bit adj,
                                       input bit r, input bit g, input bit y);
    in_item_t it;
    it.second_tick = tick;
    it.mode_normal = norm;
    it.mode_adjust = adj;
    it.red_press = r;
    it.green_press = g;
    it.yellow_press = y;
    return it;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // tvalid stays high across back-to-back transactions
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    out_item_t   res;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_lights(it, res);
    pending_lights.push_back(res);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holding) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  initial begin
    forever begin
      @(hold_ev);
      holding <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      holding <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(out_item_t)-1:0];
      if (pending_lights.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax)
          $display("unexpected result transaction: %h", m_axis_tdata);
      end else begin
        want = pending_lights.pop_front();
        if (got.lamp_red !== want.lamp_red || got.lamp_yellow !== want.lamp_yellow ||
            got.lamp_green !== want.lamp_green || got.seg_units !== want.seg_units ||
            got.seg_tens !== want.seg_tens || got.adjusting !== want.adjusting) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax)
            $display("mismatch: exp R%b Y%b G%b u=%h t=%h adj=%b, got R%b Y%b G%b u=%h t=%h adj=%b",
                     want.lamp_red, want.lamp_yellow, want.lamp_green, want.seg_units,
                     want.seg_tens, want.adjusting, got.lamp_red, got.lamp_yellow,
                     got.lamp_green, got.seg_units, got.seg_tens, got.adjusting);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle behavior: no switch, stray ticks and presses do nothing
  task automatic test_idle();
    send_item(pack_in(0, 0, 0, 0, 0, 0));
    send_item(pack_in(1, 0, 0, 0, 0, 0));
    send_item(pack_in(0, 0, 0, 1, 1, 1));
  endtask

  task automatic test_adjust();
    send_item(pack_in(0, 0, 1, 0, 0, 0));
    send_item(pack_in(0, 0, 1, 1, 0, 0));
    send_item(pack_in(1, 0, 1, 0, 1, 0));
    send_item(pack_in(0, 0, 1, 0, 0, 1));
    send_item(pack_in(0, 0, 1, 1, 1, 1));
    // both switches: presses dropped, display 00
    send_item(pack_in(1, 1, 1, 1, 1, 1));
    send_item(pack_in(0, 0, 1, 0, 0, 0));
  endtask

  // Press until every duration has wrapped past the maximum to 1
  task automatic test_wrap();
    while (!(dur_red == 7'd1 && dur_green == 7'd1 && dur_yellow == 7'd1))
      send_item(pack_in($urandom_range(0, 1), 0, 1, dur_red != 7'd1,
                        dur_green != 7'd1, dur_yellow != 7'd1));
  endtask

  task automatic test_run_cycle();
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    send_item(pack_in(0, 1, 0, 1, 0, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    send_item(pack_in(1, 1, 0, 0, 1, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    // switch off mid-cycle: run continues, ends idle after yellow
    send_item(pack_in(0, 0, 0, 0, 0, 0));
    send_item(pack_in(1, 0, 0, 0, 0, 1));
    send_item(pack_in(1, 0, 0, 0, 0, 0));
    send_item(pack_in(1, 0, 0, 0, 0, 0));
    send_item(pack_in(0, 0, 1, 1, 0, 0));
    send_item(pack_in(0, 0, 1, 1, 1, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
    // adjust request while running abandons the countdown
    send_item(pack_in(1, 1, 1, 1, 0, 1));
    send_item(pack_in(1, 1, 0, 0, 0, 0));
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    -> hold_ev;
    quiet = 1'b1;
    for (int k = 0; k < 40; k++)
      send_item(pack_in($urandom_range(0, 1), $urandom_range(0, 3) != 0,
                        $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                        $urandom_range(0, 1), $urandom_range(0, 1)));
    quiet = 1'b0;
  endtask

  // Segments: run sequences, adjust sessions, and raw noise
  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    in_item_t    it;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 4) == 0);
      if (kind < 60) len = $urandom_range(10, 80);
      else if (kind < 85) len = $urandom_range(2, 12);
      else len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        if (kind < 60) begin
          it = pack_in($urandom_range(0, 9) < 7, $urandom_range(0, 9) != 0, 0,
                       $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                       $urandom_range(0, 7) == 0);
        end else if (kind < 85) begin
          it = pack_in($urandom_range(0, 1), $urandom_range(0, 19) == 0, 1,
                       $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                       $urandom_range(0, 2) == 0);
        end else begin
          it = in_item_t'(6'($urandom));
        end
        send_item(it);
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle();
    test_adjust();
    test_wrap();
    test_run_cycle();
    test_backpressure();
    test_random(RandomItems);
    s_axis_tvalid <= 1'b0;
    while (pending_lights.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
